>>> design/assert_macros.svh
// Assertion helpers; clk_i and rst_ni must be visible where these are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("check failed");

// Next-cycle implication.
`define ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("check failed");

`endif

>>> design/mdc_pkg.sv
package mdc_pkg;

  localparam int unsigned ENTRY_W      = 16;
  localparam int unsigned DET_W        = 64;
  localparam int unsigned CHUNK_W      = 16;
  localparam int unsigned CFG_W        = 3;
  localparam int unsigned MAX_SIZE_DEF = 4;
  localparam logic [CFG_W-1:0] SIZE_RESET = 3'd3;

  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic REG_MATRIX_SIZE = 1'b0;

  localparam int unsigned UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t U_WAIT    = 4'd0;
  localparam upc_t U_INIT    = 4'd1;
  localparam upc_t U_ROW     = 4'd2;
  localparam upc_t U_COLTEST = 4'd3;
  localparam upc_t U_FETCH   = 4'd4;
  localparam upc_t U_LOAD    = 4'd5;
  localparam upc_t U_MAC     = 4'd6;
  localparam upc_t U_ACC     = 4'd7;
  localparam upc_t U_NEXT    = 4'd8;
  localparam upc_t U_STORE   = 4'd9;
  localparam upc_t U_HOLD    = 4'd10;
  localparam upc_t U_EMIT    = 4'd11;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_INIT,
    OP_ROW,
    OP_FETCH,
    OP_LOAD,
    OP_MAC,
    OP_ACC,
    OP_NEXT,
    OP_STORE,
    OP_EMIT
  } uop_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOT_START,
    C_COL_OUT,
    C_MORE_CHUNKS,
    C_MORE_COLS,
    C_MORE_MASKS,
    C_OUT_BUSY
  } ucond_e;

  typedef struct packed {
    uop_e   op;
    ucond_e cond;
    upc_t   target;
  } ucw_t;

  // Jump to target when cond holds, else advance by one.
  function automatic ucw_t ucode_rom(input upc_t upc);
    ucw_t w;
    case (upc)
      U_WAIT:    w = '{OP_NOP,   C_NOT_START,   U_WAIT};
      U_INIT:    w = '{OP_INIT,  C_NEVER,       U_WAIT};
      U_ROW:     w = '{OP_ROW,   C_NEVER,       U_WAIT};
      U_COLTEST: w = '{OP_NOP,   C_COL_OUT,     U_NEXT};
      U_FETCH:   w = '{OP_FETCH, C_NEVER,       U_WAIT};
      U_LOAD:    w = '{OP_LOAD,  C_NEVER,       U_WAIT};
      U_MAC:     w = '{OP_MAC,   C_MORE_CHUNKS, U_MAC};
      U_ACC:     w = '{OP_ACC,   C_NEVER,       U_WAIT};
      U_NEXT:    w = '{OP_NEXT,  C_MORE_COLS,   U_COLTEST};
      U_STORE:   w = '{OP_STORE, C_MORE_MASKS,  U_ROW};
      U_HOLD:    w = '{OP_NOP,   C_OUT_BUSY,    U_HOLD};
      U_EMIT:    w = '{OP_EMIT,  C_ALWAYS,      U_WAIT};
      default:   w = '{OP_NOP,   C_ALWAYS,      U_WAIT};
    endcase
    return w;
  endfunction

endpackage

>>> design/matrix_determinant_cofactor.sv
// Determinant of an n-by-n matrix of signed 16-bit entries, n = 1..MAX_SIZE.
// Input stream: one entry per request on s_axis, row-major; one entry per cycle
// while the sequencer is idle. Output stream: one request per matrix on m_axis,
// tdata = exact determinant saturated to 64 bits, tuser = overflow flag.
// APB register 0 (address 0) holds matrix_size; a write drops a partial matrix.
// Sizes 0 and above MAX_SIZE act as 1 and MAX_SIZE.
// After the last entry a microcoded sequencer evaluates the cofactor expansion
// bottom-up over column subsets, one minor memory word per subset. Each term is
// a wide-by-entry product built from C = max(MAX_SIZE+1, 5) chunk multiplies on
// one 17x17 multiplier. No entry is taken while the sequencer runs; the next
// matrix loads while the result waits in the output register. A stalled
// receiver holds the result and, if the next matrix finishes first, holds the
// sequencer before its emit step.
// Reset clears the entry count, sets matrix_size to 3 and empties the output.
`include "assert_macros.svh"

module matrix_determinant_cofactor
  import mdc_pkg::*;
#(
  parameter int unsigned MAX_SIZE = MAX_SIZE_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [ENTRY_W-1:0]  s_axis_tdata,   // [15:0] entry_value
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [DET_W-1:0]    m_axis_tdata,   // [63:0] determinant
  output logic [0:0]          m_axis_tuser,   // [0] overflow
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready
);

  localparam int unsigned DEPTH   = MAX_SIZE * MAX_SIZE;
  localparam int unsigned ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned N_W     = $clog2(MAX_SIZE + 1);
  localparam int unsigned COL_W   = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int unsigned NCHUNK  = (MAX_SIZE + 1 > 5) ? MAX_SIZE + 1 : 5;
  localparam int unsigned ACC_W   = CHUNK_W * NCHUNK;
  localparam int unsigned K_W     = $clog2(NCHUNK);
  localparam int unsigned MDEPTH  = 2 ** MAX_SIZE;
  localparam int unsigned PROD_W  = 2 * (CHUNK_W + 1);
  localparam int unsigned RA_W    = 2 * N_W + 1;

  // control registers
  upc_t                upc_q, upc_d;
  logic [CNT_W-1:0]    cnt_q;
  logic [CFG_W-1:0]    size_q;
  logic [MAX_SIZE-1:0] mask_q;
  logic [COL_W-1:0]    col_q;
  logic                neg_q;
  logic [K_W-1:0]      k_q;
  logic                m_valid_q;

  // datapath registers
  logic [ACC_W-1:0]          sum_q;
  logic [ACC_W-1:0]          term_q;
  logic [ACC_W-1:0]          term_d;
  logic [ACC_W-1:0]          mdat_q;
  logic [ACC_W-1:0]          rd_q;
  logic [ENTRY_W-1:0]        ent_rd_q;
  logic signed [ENTRY_W:0]   ent_q;
  logic [DET_W-1:0]          det_q;
  logic                      ovf_q;

  logic [ENTRY_W-1:0] entry_store [DEPTH];
  logic [ACC_W-1:0]   minor_mem   [MDEPTH];

  ucw_t                ucw;
  logic                jump;
  logic                in_acc;
  logic                start;
  logic                cfg_we;
  logic [N_W-1:0]      n_w;
  logic [2*N_W-1:0]    nn_full;
  logic [CNT_W-1:0]    nn;
  logic [N_W-1:0]      pop;
  logic [N_W-1:0]      row;
  logic [RA_W-1:0]     eaddr_full;
  logic [ADDR_W-1:0]   eaddr;
  logic [MAX_SIZE-1:0] colbit;
  logic [MAX_SIZE-1:0] full;
  logic [MAX_SIZE-1:0] raddr;
  logic                col_in;
  logic signed [ENTRY_W:0]   ent_x;
  logic signed [ENTRY_W:0]   ent_signed;
  logic [CHUNK_W-1:0]        top;
  logic signed [CHUNK_W:0]   chunk_s;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   prod_x;
  logic                      mem_we;
  logic [MAX_SIZE-1:0]       mem_waddr;
  logic [ACC_W-1:0]          mem_wdata;
  logic [ACC_W-DET_W:0]      hi_bits;
  logic                      fits;
  logic [DET_W-1:0]          det_sat;

  // size, handshakes
  always_comb begin
    if (size_q == '0) begin
      n_w = N_W'(1);
    end else if (size_q > CFG_W'(MAX_SIZE)) begin
      n_w = N_W'(MAX_SIZE);
    end else begin
      n_w = N_W'(size_q);
    end
  end

  assign nn_full       = (2*N_W)'(n_w) * (2*N_W)'(n_w);
  assign nn            = CNT_W'(nn_full);
  assign s_axis_tready = (upc_q == U_WAIT);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign start         = in_acc && (cnt_q == nn - CNT_W'(1));
  assign cfg_we        = psel & penable & pwrite & pready & (paddr[2] == REG_MATRIX_SIZE);
  assign pready        = 1'b1;
  assign prdata        = (paddr[2] == REG_MATRIX_SIZE) ? APB_DW'(size_q) : '0;

  // subset addressing
  always_comb begin
    pop = '0;
    for (int i = 0; i < MAX_SIZE; i++) begin
      pop       = pop + N_W'(mask_q[i]);
      colbit[i] = (col_q == COL_W'(i));
      full[i]   = (i < int'(n_w));
    end
  end

  assign row        = n_w - pop;
  assign eaddr_full = RA_W'(row) * RA_W'(n_w) + RA_W'(col_q);
  assign eaddr      = eaddr_full[ADDR_W-1:0];
  assign raddr      = mask_q & ~colbit;
  assign col_in     = |(mask_q & colbit);

  // entry with cofactor sign
  assign ent_x      = {ent_rd_q[ENTRY_W-1], ent_rd_q};
  assign ent_signed = neg_q ? -ent_x : ent_x;

  // chunk multiply, most significant chunk first
  assign top     = mdat_q[ACC_W-1 -: CHUNK_W];
  assign chunk_s = (k_q == '0) ? {top[CHUNK_W-1], top} : {1'b0, top};
  assign prod    = chunk_s * ent_q;
  assign prod_x  = ACC_W'(prod);
  assign term_d  = (term_q << CHUNK_W) + prod_x;

  // saturation
  assign hi_bits = sum_q[ACC_W-1:DET_W-1];
  assign fits    = (&hi_bits) | ~(|hi_bits);
  assign det_sat = fits ? sum_q[DET_W-1:0] :
                   (sum_q[ACC_W-1] ? {1'b1, {(DET_W-1){1'b0}}} :
                                     {1'b0, {(DET_W-1){1'b1}}});

  // minor memory write port
  assign mem_we    = (ucw.op == OP_INIT) || (ucw.op == OP_STORE);
  assign mem_waddr = (ucw.op == OP_INIT) ? '0 : mask_q;
  assign mem_wdata = (ucw.op == OP_INIT) ? ACC_W'(1) : sum_q;

  // sequencer
  always_comb begin
    ucw = ucode_rom(upc_q);
    case (ucw.cond)
      C_NEVER:       jump = 1'b0;
      C_ALWAYS:      jump = 1'b1;
      C_NOT_START:   jump = !start;
      C_COL_OUT:     jump = !col_in;
      C_MORE_CHUNKS: jump = (k_q != K_W'(NCHUNK - 1));
      C_MORE_COLS:   jump = (N_W'(col_q) != n_w - N_W'(1));
      C_MORE_MASKS:  jump = (mask_q != full);
      C_OUT_BUSY:    jump = m_valid_q & !m_axis_tready;
      default:       jump = 1'b0;
    endcase
    upc_d = jump ? ucw.target : upc_q + UPC_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q     <= U_WAIT;
      cnt_q     <= '0;
      size_q    <= SIZE_RESET;
      mask_q    <= '0;
      col_q     <= '0;
      neg_q     <= 1'b0;
      k_q       <= '0;
      m_valid_q <= 1'b0;
    end else begin
      upc_q <= upc_d;
      if (cfg_we) begin
        size_q <= pwdata[CFG_W-1:0];
        cnt_q  <= '0;
      end else if (in_acc) begin
        cnt_q <= start ? '0 : cnt_q + CNT_W'(1);
      end
      case (ucw.op)
        OP_INIT:  mask_q <= MAX_SIZE'(1);
        OP_ROW: begin
          col_q <= '0;
          neg_q <= 1'b0;
        end
        OP_FETCH: k_q    <= '0;
        OP_MAC:   k_q    <= k_q + K_W'(1);
        OP_ACC:   neg_q  <= !neg_q;
        OP_NEXT:  col_q  <= col_q + COL_W'(1);
        OP_STORE: mask_q <= mask_q + MAX_SIZE'(1);
        default: ;
      endcase
      if (ucw.op == OP_EMIT) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      entry_store[cnt_q[ADDR_W-1:0]] <= s_axis_tdata;
    end
    ent_rd_q <= entry_store[eaddr];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      minor_mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= minor_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    case (ucw.op)
      OP_ROW: sum_q <= '0;
      OP_FETCH: begin
        ent_q  <= ent_signed;
        term_q <= '0;
      end
      OP_LOAD: mdat_q <= rd_q;
      OP_MAC: begin
        term_q <= term_d;
        mdat_q <= mdat_q << CHUNK_W;
      end
      OP_ACC: sum_q <= sum_q + term_q;
      OP_EMIT: begin
        det_q <= det_sat;
        ovf_q <= !fits;
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = det_q;
  assign m_axis_tuser  = ovf_q;

  `ASSERT_IMP(a_run_count_clear, upc_q != U_WAIT, cnt_q == '0)
  `ASSERT_NEXT(a_emit_valid, ucw.op == OP_EMIT, m_axis_tvalid)
  `ASSERT_IMP(a_row_mask_set, upc_q == U_ROW, mask_q != '0)
  `ASSERT_IMP(a_mac_bound, upc_q == U_MAC, int'(k_q) < NCHUNK)

endmodule
